// ===== design/cfcb_pkg.sv =====
// Shared constants, register indexes, mode codes and pixel helpers for the
// clipped fill/copy/blend pixel core. No dependencies.
package cfcb_pkg;

  localparam int MAX_DIM     = 8192;
  localparam int COORD_BITS  = 16;
  localparam int DIM_BITS    = 14;
  localparam int POS_BITS    = $clog2(MAX_DIM);
  localparam int IDX_BITS    = 26;
  localparam int PIX_BITS    = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int IN_TDATA_BITS  = 4 * COORD_BITS + 2 * PIX_BITS;
  localparam int OUT_TDATA_BITS = ((IDX_BITS + PIX_BITS + 7) / 8) * 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_OP_MODE       = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLEND_ALPHA   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_FILL_COLOR    = 3'd6;

  // Operation modes
  localparam logic [1:0] MODE_FILL  = 2'd0;
  localparam logic [1:0] MODE_COPY  = 2'd1;
  localparam logic [1:0] MODE_BLEND = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  localparam logic [7:0] ALPHA_RESET = 8'hFF;

  // Clamp a size register to the largest supported dimension
  function automatic logic [DIM_BITS-1:0] dim_of(input logic [DIM_BITS-1:0] v);
    return (v > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : v;
  endfunction

  // True when (x, y) lies in a w by h rectangle anchored at the origin
  function automatic logic in_bounds(input logic [COORD_BITS-1:0] x,
                                     input logic [COORD_BITS-1:0] y,
                                     input logic [DIM_BITS-1:0]   w,
                                     input logic [DIM_BITS-1:0]   h);
    return !x[COORD_BITS-1] && !y[COORD_BITS-1] &&
           (x < COORD_BITS'(dim_of(w))) && (y < COORD_BITS'(dim_of(h)));
  endfunction

  // (s*a + d*(255-a)) / 255, truncated; the divide is the exact
  // (x + (x >> 8) + 1) >> 8 form, valid for any 16-bit weighted sum here
  function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
                                     input logic [7:0] a);
    logic [15:0] x;
    logic [16:0] t;
    x = 16'(s * a) + 16'(d * (8'd255 - a));
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

// ===== design/clipped_fill_copy_blend_pixel_top.sv =====
// Pixel core of a 2D blitter: clipping, linear index and fill/copy/blend.
// Depends on cfcb_pkg.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------------
//  s_*     | in  | s_tvalid / s_tready | s_tdata coords+pixels, s_tlast last pixel
//  m_*     | out | m_tvalid / m_tready | m_tdata index+pixel, m_tuser write enable
//  cfg_*   | in  | cfg_we              | cfg_index, cfg_data
//
// One request per clock sustained while m_tready stays high; the path is an input register
// followed by the result register, with the index multiply and channel mix
// between them. Reset is synchronous: both stages empty, registers at their
// reset values (blend_alpha 255, all others 0). With m_tready low the result
// holds and one more request is taken into the input register.
module clipped_fill_copy_blend_pixel_top
  import cfcb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // dest_x[15:0], dest_y[31:16], src_x[47:32], src_y[63:48],
  // src_pixel[95:64], dest_pixel[127:96]
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,
  input  logic                      s_tlast,   // last_pixel
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // dest_index[25:0], pixel_out[57:26], zero[63:58]
  output logic [OUT_TDATA_BITS-1:0] m_tdata,
  output logic                      m_tuser,   // write_enable
  output logic                      m_tlast,   // op_done
  input  logic                      cfg_we,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int PAD_BITS = OUT_TDATA_BITS - IDX_BITS - PIX_BITS;
  localparam int PROD_BITS = POS_BITS + DIM_BITS;

  logic [DIM_BITS-1:0] frame_width, frame_height, source_width, source_height;
  logic [1:0]          op_mode;
  logic [7:0]          blend_alpha;
  logic [PIX_BITS-1:0] fill_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= '0;
      frame_height  <= '0;
      source_width  <= '0;
      source_height <= '0;
      op_mode       <= MODE_FILL;
      blend_alpha   <= ALPHA_RESET;
      fill_color    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:   frame_width   <= cfg_data[DIM_BITS-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data[DIM_BITS-1:0];
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[DIM_BITS-1:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[DIM_BITS-1:0];
        REG_OP_MODE:       op_mode       <= cfg_data[1:0];
        REG_BLEND_ALPHA:   blend_alpha   <= cfg_data[7:0];
        REG_FILL_COLOR:    fill_color    <= cfg_data[PIX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input stage
  logic                     in_valid;
  logic [COORD_BITS-1:0]    in_dx, in_dy, in_sx, in_sy;
  logic [PIX_BITS-1:0]      in_sp, in_dp;
  logic                     in_last;
  logic                     advance;

  // Result stage
  logic                     out_valid;
  logic                     out_we;
  logic [IDX_BITS-1:0]      out_idx;
  logic [PIX_BITS-1:0]      out_pix;
  logic                     out_last;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_dx   <= s_tdata[COORD_BITS-1:0];
      in_dy   <= s_tdata[2*COORD_BITS-1:COORD_BITS];
      in_sx   <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
      in_sy   <= s_tdata[4*COORD_BITS-1:3*COORD_BITS];
      in_sp   <= s_tdata[4*COORD_BITS+PIX_BITS-1:4*COORD_BITS];
      in_dp   <= s_tdata[4*COORD_BITS+2*PIX_BITS-1:4*COORD_BITS+PIX_BITS];
      in_last <= s_tlast;
    end
  end

  logic                 dest_ok, src_ok, we_next;
  logic [PROD_BITS-1:0] idx_sum;
  logic [PIX_BITS-1:0]  pix_calc;
  logic [IDX_BITS-1:0]  idx_next;
  logic [PIX_BITS-1:0]  pix_next;

  always_comb begin
    dest_ok = in_bounds(in_dx, in_dy, frame_width, frame_height);
    src_ok  = in_bounds(in_sx, in_sy, source_width, source_height);
    we_next = (blend_alpha != 8'd0) && (op_mode != MODE_RSVD) && dest_ok &&
              ((op_mode == MODE_FILL) || src_ok);

    // Row and column are below MAX_DIM whenever the pixel is written
    idx_sum = PROD_BITS'(PROD_BITS'(in_dy[POS_BITS-1:0]) *
                         PROD_BITS'(dim_of(frame_width))) +
              PROD_BITS'(in_dx[POS_BITS-1:0]);

    case (op_mode)
      MODE_FILL: pix_calc = fill_color;
      MODE_COPY: pix_calc = in_sp;
      default:   pix_calc = {8'h00,
                             mix(in_sp[23:16], in_dp[23:16], blend_alpha),
                             mix(in_sp[15:8],  in_dp[15:8],  blend_alpha),
                             mix(in_sp[7:0],   in_dp[7:0],   blend_alpha)};
    endcase

    idx_next = we_next ? idx_sum[IDX_BITS-1:0] : '0;
    pix_next = we_next ? pix_calc : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_we   <= we_next;
      out_idx  <= idx_next;
      out_pix  <= pix_next;
      out_last <= in_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD_BITS{1'b0}}, out_pix, out_idx};
  assign m_tuser  = out_we;
  assign m_tlast  = out_last;

  // A suppressed write carries an all-zero payload
  a_nowrite_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("suppressed write with nonzero payload");

  // Input register only blocks when it is full and the result stage is stuck
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled without backpressure");

  // A held request moves to the result stage on the next edge
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (in_valid && advance) |=> m_tvalid)
    else $error("request lost between stages");

  // Blend results clear the top byte
  a_blend_top: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser && (op_mode == MODE_BLEND)) |-> (out_pix[31:24] == 8'h00))
    else $error("blend result with nonzero top byte");

  // No write can happen with alpha zero or the unused mode
  a_no_write_mode: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((blend_alpha == 8'd0) || (op_mode == MODE_RSVD))) |-> !m_tuser)
    else $error("write with alpha zero or unused mode");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the clipped fill/copy/blend pixel core: directed corner
// requests, then randomized phases with source gaps and sink stalls.
// Depends on cfcb_pkg and clipped_fill_copy_blend_pixel_top.
module testbench;
  import cfcb_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int HOLD_CYCLES     = 300;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;

  typedef struct {
    logic signed [COORD_BITS-1:0] dx;
    logic signed [COORD_BITS-1:0] dy;
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic [PIX_BITS-1:0]          spix;
    logic [PIX_BITS-1:0]          dpix;
    logic                         last_px;
  } pixel_request_t;

  typedef struct {
    logic                we;
    logic [IDX_BITS-1:0] idx;
    logic [PIX_BITS-1:0] pix;
    logic                done;
    logic [5:0]          pad;
  } pixel_write_t;

  class pixel_scoreboard;
    logic [DIM_BITS-1:0] fw, fh, sw, sh;
    logic [1:0]          mode;
    logic [7:0]          alpha;
    logic [PIX_BITS-1:0] fill;
    pixel_write_t        pending_writes[$];
    int                  errors;

    function void reset_regs();
      fw = '0; fh = '0; sw = '0; sh = '0;
      mode = MODE_FILL;
      alpha = ALPHA_RESET;
      fill = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_FRAME_WIDTH:   fw = data[DIM_BITS-1:0];
        REG_FRAME_HEIGHT:  fh = data[DIM_BITS-1:0];
        REG_SOURCE_WIDTH:  sw = data[DIM_BITS-1:0];
        REG_SOURCE_HEIGHT: sh = data[DIM_BITS-1:0];
        REG_OP_MODE:       mode = data[1:0];
        REG_BLEND_ALPHA:   alpha = data[7:0];
        REG_FILL_COLOR:    fill = data[PIX_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int clamp_dim(logic [DIM_BITS-1:0] v);
      return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    function bit in_rect(logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
                         logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h);
      int xi, yi;
      xi = x;
      yi = y;
      return xi >= 0 && yi >= 0 && xi < clamp_dim(w) && yi < clamp_dim(h);
    endfunction

    function logic [7:0] blend_channel(logic [7:0] s, logic [7:0] d, logic [7:0] a);
      int unsigned si, di, ai;
      si = s;
      di = d;
      ai = a;
      return 8'((si * ai + di * (255 - ai)) / 255);
    endfunction

    function void note_request(pixel_request_t r);
      pixel_write_t w;
      int unsigned  lin;
      w.we = 1'b0;
      w.idx = '0;
      w.pix = '0;
      w.pad = '0;
      w.done = r.last_px;
      if (alpha != 0 && mode != MODE_RSVD && in_rect(r.dx, r.dy, fw, fh)) begin
        if (mode == MODE_FILL) begin
          w.we = 1'b1;
          w.pix = fill;
        end else if (in_rect(r.sx, r.sy, sw, sh)) begin
          w.we = 1'b1;
          if (mode == MODE_COPY) begin
            w.pix = r.spix;
          end else begin
            w.pix = {8'h00,
                     blend_channel(r.spix[23:16], r.dpix[23:16], alpha),
                     blend_channel(r.spix[15:8],  r.dpix[15:8],  alpha),
                     blend_channel(r.spix[7:0],   r.dpix[7:0],   alpha)};
          end
        end
      end
      if (w.we) begin
        lin = int'(r.dy) * clamp_dim(fw) + int'(r.dx);
        w.idx = lin[IDX_BITS-1:0];
      end
      pending_writes.push_back(w);
    endfunction

    function void check_result(pixel_write_t got);
      pixel_write_t want;
      if (pending_writes.size() == 0) begin
        $error("result with no request pending: index %0h pixel %0h", got.idx, got.pix);
        errors++;
        return;
      end
      want = pending_writes.pop_front();
      if (got.we !== want.we) begin
        $error("write_enable: expected %0h actual %0h", want.we, got.we);
        errors++;
      end
      if (got.idx !== want.idx) begin
        $error("dest_index: expected %0h actual %0h", want.idx, got.idx);
        errors++;
      end
      if (got.pix !== want.pix) begin
        $error("pixel_out: expected %0h actual %0h", want.pix, got.pix);
        errors++;
      end
      if (got.done !== want.done) begin
        $error("op_done: expected %0h actual %0h", want.done, got.done);
        errors++;
      end
      if (got.pad !== want.pad) begin
        $error("tdata padding: expected %0h actual %0h", want.pad, got.pad);
        errors++;
      end
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
  logic                      s_tlast = 1'b0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic                      m_tuser;
  logic                      m_tlast;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  pixel_scoreboard board = new();
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  clipped_fill_copy_blend_pixel_top uut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_we, .cfg_index, .cfg_data
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    #(400_000 * CLK_PERIOD);
    $display("RESULT: ERROR");
    $finish;
  end

  // Sink side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Observe all three ports at the edge, before any driven update lands
  always @(posedge clk) begin
    pixel_request_t req;
    pixel_write_t   res;
    if (rst) begin
      board.reset_regs();
    end else begin
      if (m_tvalid && m_tready) begin
        res.we = m_tuser;
        res.idx = m_tdata[IDX_BITS-1:0];
        res.pix = m_tdata[IDX_BITS +: PIX_BITS];
        res.pad = m_tdata[OUT_TDATA_BITS-1 -: 6];
        res.done = m_tlast;
        board.check_result(res);
      end
      if (s_tvalid && s_tready) begin
        req.dx = s_tdata[15:0];
        req.dy = s_tdata[31:16];
        req.sx = s_tdata[47:32];
        req.sy = s_tdata[63:48];
        req.spix = s_tdata[95:64];
        req.dpix = s_tdata[127:96];
        req.last_px = s_tlast;
        board.note_request(req);
      end
      if (cfg_we) board.write_reg(cfg_index, cfg_data);
    end
  end

  task automatic push_pixel(pixel_request_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {r.dpix, r.spix, r.sy, r.sx, r.dy, r.dx};
    s_tlast <= r.last_px;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_at(int dx, int dy, int sx, int sy, logic [31:0] spix,
                         logic [31:0] dpix, bit last_px);
    pixel_request_t r;
    r.dx = 16'(dx);
    r.dy = 16'(dy);
    r.sx = 16'(sx);
    r.sy = 16'(sy);
    r.spix = spix;
    r.dpix = dpix;
    r.last_px = last_px;
    push_pixel(r);
  endtask

  // Drop valid and wait until every request has come back out
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val, int bits);
    logic [31:0] junk;
    junk = ($urandom_range(3) == 0) ? ($urandom << bits) : 32'd0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val | junk;
    @(posedge clk);
  endtask

  task automatic program_regs(int fw, int fh, int sw, int sh, logic [1:0] mode,
                              logic [7:0] alpha, logic [31:0] fill);
    drain();
    set_reg(REG_FRAME_WIDTH, 32'(fw), DIM_BITS);
    set_reg(REG_FRAME_HEIGHT, 32'(fh), DIM_BITS);
    set_reg(REG_SOURCE_WIDTH, 32'(sw), DIM_BITS);
    set_reg(REG_SOURCE_HEIGHT, 32'(sh), DIM_BITS);
    set_reg(REG_OP_MODE, 32'(mode), 2);
    set_reg(REG_BLEND_ALPHA, 32'(alpha), 8);
    set_reg(REG_FILL_COLOR, fill, 32);
    // unmapped index must leave everything alone
    if ($urandom_range(3) == 0) set_reg(REG_SPARE, $urandom, 32);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_dim();
    case ($urandom_range(11))
      0: return 0;
      1: return 1;
      2: return MAX_DIM;
      3: return $urandom_range(MAX_DIM + 1, 16383);
      4: return 16383;
      5: return $urandom_range(MAX_DIM);
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  function automatic logic [15:0] pick_coord(int dim);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return (dim > 0) ? 16'($urandom_range(dim - 1)) : 16'($urandom);
      5: return 16'(dim - 1);
      6: return 16'(dim);
      7: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic program_random();
    logic [1:0]  mode;
    logic [7:0]  alpha;
    logic [31:0] fill;
    case ($urandom_range(9))
      0, 1, 2: mode = MODE_FILL;
      3, 4, 5: mode = MODE_COPY;
      6, 7, 8: mode = MODE_BLEND;
      default: mode = MODE_RSVD;
    endcase
    case ($urandom_range(9))
      0: alpha = 8'd0;
      1: alpha = 8'd255;
      2: alpha = 8'd1;
      default: alpha = 8'($urandom);
    endcase
    case ($urandom_range(5))
      0: fill = 32'h0;
      1: fill = 32'hFFFF_FFFF;
      default: fill = $urandom;
    endcase
    program_regs(pick_dim(), pick_dim(), pick_dim(), pick_dim(), mode, alpha, fill);
  endtask

  initial begin
    pixel_request_t r;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset sizes are zero: everything clips
    send_at(0, 0, 0, 0, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0);

    program_regs(100, 50, 60, 40, MODE_FILL, 8'd255, 32'hDEAD_BEEF);
    send_at(0, 0, -5, -5, 32'h0, 32'h0, 1'b0);
    send_at(99, 49, 0, 0, 32'h0, 32'h0, 1'b0);
    send_at(100, 0, 0, 0, 32'h0, 32'h0, 1'b0);
    send_at(0, 50, 0, 0, 32'h0, 32'h0, 1'b0);
    send_at(-1, 0, 0, 0, 32'h0, 32'h0, 1'b0);
    send_at(0, -1, 0, 0, 32'h0, 32'h0, 1'b0);
    send_at(-32768, 32767, 32767, -32768, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

    program_regs(100, 50, 60, 40, MODE_COPY, 8'd255, 32'h0);
    send_at(5, 5, 59, 39, 32'hFFFF_FFFF, 32'h0, 1'b0);
    send_at(5, 5, 60, 0, 32'hFFFF_FFFF, 32'h0, 1'b0);
    send_at(5, 5, 0, 40, 32'hFFFF_FFFF, 32'h0, 1'b0);
    send_at(5, 5, -1, 0, 32'hFFFF_FFFF, 32'h0, 1'b1);

    program_regs(100, 50, 60, 40, MODE_BLEND, 8'd128, 32'h0);
    send_at(7, 3, 7, 3, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_at(7, 3, 7, 3, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    program_regs(100, 50, 60, 40, MODE_BLEND, 8'd255, 32'h0);
    send_at(8, 3, 8, 3, 32'h5A12_3456, 32'hA5FE_DCBA, 1'b0);
    program_regs(100, 50, 60, 40, MODE_BLEND, 8'd1, 32'h0);
    send_at(9, 3, 9, 3, 32'h00FF_80FF, 32'h0000_7F01, 1'b0);
    program_regs(100, 50, 60, 40, MODE_BLEND, 8'd0, 32'h0);
    send_at(9, 3, 9, 3, 32'h00FF_80FF, 32'h0000_7F01, 1'b1);

    program_regs(100, 50, 60, 40, MODE_RSVD, 8'd255, 32'hCAFE_F00D);
    send_at(1, 1, 1, 1, 32'h1111_1111, 32'h2222_2222, 1'b0);

    // oversize registers clamp to the largest frame
    program_regs(16383, 16383, 16383, 16383, MODE_FILL, 8'd255, 32'h8000_0001);
    send_at(8191, 8191, 0, 0, 32'h0, 32'h0, 1'b0);
    send_at(8192, 0, 0, 0, 32'h0, 32'h0, 1'b0);

    program_regs(1, 1, 1, 1, MODE_COPY, 8'd200, 32'h0);
    send_at(0, 0, 0, 0, 32'h0F0F_0F0F, 32'h0, 1'b0);
    send_at(1, 0, 0, 0, 32'h0F0F_0F0F, 32'h0, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      program_random();
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 68; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 68; end
        default: begin src_idle_pct = 27; sink_stall_pct = 27; end
      endcase
      // hold the sink off while the source keeps pushing
      if (ph % 4 == 0 && ph < 8) hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r.dx = pick_coord(board.clamp_dim(board.fw));
        r.dy = pick_coord(board.clamp_dim(board.fh));
        r.sx = pick_coord(board.clamp_dim(board.sw));
        r.sy = pick_coord(board.clamp_dim(board.sh));
        r.spix = $urandom;
        r.dpix = $urandom;
        r.last_px = (n == ITEMS_PER_PHASE - 1) || ($urandom_range(15) == 0);
        push_pixel(r);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
